// ----- rtl/tpst_pkg.sv -----
// shared constants, command/status structs and codes for the stencil time stepper
// no dependencies; imported by every module of the block
package tpst_pkg;

  localparam int GRID_POINTS = 1024;
  localparam int ADDR_W      = $clog2(GRID_POINTS);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int DATA_W      = 32;
  localparam int COEF_W      = 32;
  localparam int FRAC_W      = 30;
  localparam int EDGE_W      = 31;
  localparam int STEPS_W     = 16;
  localparam int PROD_W      = DATA_W + COEF_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int CFG_IDX_W   = 3;

  localparam logic signed [COEF_W-1:0] COEF_CENTER_RST = 32'sh4000_0000;
  localparam logic [STEPS_W-1:0]       NUM_STEPS_RST   = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_LOWER  = 3'd0,
    CFG_COEF_CENTER = 3'd1,
    CFG_COEF_UPPER  = 3'd2,
    CFG_LOW_EDGE    = 3'd3,
    CFG_NUM_STEPS   = 3'd4
  } cfg_idx_e;

  // which neighbor a multiply belongs to
  typedef enum logic [1:0] {
    PH_LOWER  = 2'd0,
    PH_CENTER = 2'd1,
    PH_UPPER  = 2'd2
  } phase_e;

  typedef struct packed {
    logic              load_wr;
    logic [ADDR_W-1:0] load_addr;
    logic              edge_wr;
    logic [ADDR_W-1:0] edge_addr;
    logic              edge_low;
    logic              mac_issue;
    logic [ADDR_W-1:0] rd_addr;
    phase_e            phase;
    logic [ADDR_W-1:0] point;
    logic              src_sel;
    logic              capture;
    logic              capture_zero;
  } tpst_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } tpst_status_t;

endpackage

// ----- rtl/tpst_datapath.sv -----
// datapath: ping-pong grid memories, shared multiply-accumulate, rounding and output register
// depends on tpst_pkg; driven by tpst_ctrl through tpst_cmd_t
module tpst_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tpst_pkg::tpst_cmd_t                  cmd_i,
  input  logic signed [tpst_pkg::DATA_W-1:0]   payoff_value_i,
  input  logic signed [tpst_pkg::COEF_W-1:0]   coef_lower_i,
  input  logic signed [tpst_pkg::COEF_W-1:0]   coef_center_i,
  input  logic signed [tpst_pkg::COEF_W-1:0]   coef_upper_i,
  input  logic        [tpst_pkg::EDGE_W-1:0]   low_edge_i,
  output tpst_pkg::tpst_status_t               status_o,
  output logic signed [tpst_pkg::DATA_W-1:0]   option_value_o
);
  import tpst_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [DATA_W-1:0] mem_a [GRID_POINTS];
  logic signed [DATA_W-1:0] mem_b [GRID_POINTS];
  logic signed [DATA_W-1:0] rd_a_q, rd_b_q, src_data;

  // pipeline tags
  logic              s1_valid_q, s2_valid_q, s3_valid_q;
  phase_e            s1_phase_q, s2_phase_q;
  logic [ADDR_W-1:0] s1_point_q, s2_point_q, s3_point_q;

  logic signed [COEF_W-1:0] coef_sel;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q, rnd_sum, rnd_shift;
  logic signed [DATA_W-1:0] result;
  logic signed [DATA_W-1:0] option_d, option_q;

  logic                     step_wr, wr_a, wr_b;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign src_data = cmd_i.src_sel ? rd_b_q : rd_a_q;

  always_comb begin
    case (s1_phase_q)
      PH_LOWER:  coef_sel = coef_lower_i;
      PH_CENTER: coef_sel = coef_center_i;
      PH_UPPER:  coef_sel = coef_upper_i;
      default:   coef_sel = '0;
    endcase
  end

  assign prod_d = coef_sel * src_data;
  assign acc_d  = ((s2_phase_q == PH_LOWER) ? '0 : acc_q) + ACC_W'(prod_q);

  // round half up at the q30 point, then clamp to 32 bits
  always_comb begin
    rnd_sum   = acc_q + HALF_LSB;
    rnd_shift = rnd_sum >>> FRAC_W;
    if (rnd_shift > SAT_HI) begin
      result = DATA_MAX;
    end else if (rnd_shift < SAT_LO) begin
      result = DATA_MIN;
    end else begin
      result = rnd_shift[DATA_W-1:0];
    end
  end

  // single write port per grid: load goes to grid a, step writes go to the destination grid
  always_comb begin
    step_wr = s3_valid_q | cmd_i.edge_wr;
    wr_a    = cmd_i.load_wr | (step_wr & cmd_i.src_sel);
    wr_b    = step_wr & ~cmd_i.src_sel;
    if (cmd_i.load_wr) begin
      wr_addr = cmd_i.load_addr;
      wr_data = payoff_value_i;
    end else if (cmd_i.edge_wr) begin
      wr_addr = cmd_i.edge_addr;
      wr_data = cmd_i.edge_low ? $signed({1'b0, low_edge_i}) : '0;
    end else begin
      wr_addr = s3_point_q;
      wr_data = result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_a[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b_q <= mem_b[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.mac_issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q & (s2_phase_q == PH_UPPER);
    end
  end

  assign option_d = cmd_i.capture_zero ? '0 : src_data;

  always_ff @(posedge clk_i) begin
    s1_phase_q <= cmd_i.phase;
    s1_point_q <= cmd_i.point;
    s2_phase_q <= s1_phase_q;
    s2_point_q <= s1_point_q;
    s3_point_q <= s2_point_q;
    prod_q     <= prod_d;
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
    if (cmd_i.capture) begin
      option_q <= option_d;
    end
  end

  assign status_o.pipe_busy = s1_valid_q | s2_valid_q | s3_valid_q;
  assign option_value_o     = option_q;

endmodule

// ----- rtl/tpst_ctrl.sv -----
// controller: load counting, grid check, step/point/phase sequencing, result strobe
// depends on tpst_pkg; commands tpst_datapath through tpst_cmd_t
module tpst_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                last_i,
  input  logic [tpst_pkg::STEPS_W-1:0]        num_steps_i,
  input  tpst_pkg::tpst_status_t              status_i,
  output tpst_pkg::tpst_cmd_t                 cmd_o,
  output logic                                busy_o,
  output logic                                done_o,
  output logic                                grid_error_o
);
  import tpst_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_EDGE_LO,
    S_EDGE_HI,
    S_RUN,
    S_DRAIN,
    S_OUT_RD,
    S_OUT_CAP
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q, n_q, n_now;
  logic               ovf_q, ovf_now, stored, accept, bad_grid;
  logic [STEPS_W-1:0] steps_q;
  logic [ADDR_W-1:0]  m_q, last_m, center, high_addr;
  phase_e             phase_q, phase_nx;
  logic               src_sel_q, done_q, err_q;

  always_comb begin
    accept    = start_i & (state_q == S_LOAD);
    stored    = count_q < CNT_W'(GRID_POINTS);
    n_now     = stored ? count_q + CNT_W'(1) : count_q;
    ovf_now   = ovf_q | ~stored;
    bad_grid  = ovf_now | (n_now < CNT_W'(3)) | ~n_now[0];
    last_m    = n_q[ADDR_W-1:0] - ADDR_W'(2);
    high_addr = n_q[ADDR_W-1:0] - ADDR_W'(1);
    center    = n_q[ADDR_W:1];
    case (phase_q)
      PH_LOWER:  phase_nx = PH_CENTER;
      PH_CENTER: phase_nx = PH_UPPER;
      PH_UPPER:  phase_nx = PH_LOWER;
      default:   phase_nx = PH_LOWER;
    endcase
  end

  always_comb begin
    cmd_o              = '0;
    cmd_o.load_wr      = accept & stored;
    cmd_o.load_addr    = count_q[ADDR_W-1:0];
    cmd_o.edge_wr      = (state_q == S_EDGE_LO) | (state_q == S_EDGE_HI);
    cmd_o.edge_addr    = (state_q == S_EDGE_LO) ? '0 : high_addr;
    cmd_o.edge_low     = (state_q == S_EDGE_LO);
    cmd_o.mac_issue    = (state_q == S_RUN);
    cmd_o.rd_addr      = (state_q == S_RUN) ? m_q + ADDR_W'(phase_q) - ADDR_W'(1) : center;
    cmd_o.phase        = phase_q;
    cmd_o.point        = m_q;
    cmd_o.src_sel      = src_sel_q;
    cmd_o.capture      = (state_q == S_OUT_CAP);
    cmd_o.capture_zero = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      n_q       <= '0;
      steps_q   <= '0;
      m_q       <= '0;
      phase_q   <= PH_LOWER;
      src_sel_q <= 1'b0;
      done_q    <= 1'b0;
      err_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (last_i) begin
              count_q   <= '0;
              ovf_q     <= 1'b0;
              n_q       <= n_now;
              steps_q   <= num_steps_i;
              src_sel_q <= 1'b0;
              err_q     <= bad_grid;
              if (bad_grid) begin
                state_q <= S_OUT_CAP;
              end else if (num_steps_i == '0) begin
                state_q <= S_OUT_RD;
              end else begin
                state_q <= S_EDGE_LO;
              end
            end else begin
              count_q <= n_now;
              ovf_q   <= ovf_now;
            end
          end
        end
        S_EDGE_LO: begin
          state_q <= S_EDGE_HI;
        end
        S_EDGE_HI: begin
          m_q     <= ADDR_W'(1);
          phase_q <= PH_LOWER;
          state_q <= S_RUN;
        end
        S_RUN: begin
          phase_q <= phase_nx;
          if (phase_q == PH_UPPER) begin
            m_q <= m_q + ADDR_W'(1);
            if (m_q == last_m) begin
              state_q <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (!status_i.pipe_busy) begin
            src_sel_q <= ~src_sel_q;
            steps_q   <= steps_q - STEPS_W'(1);
            state_q   <= (steps_q == STEPS_W'(1)) ? S_OUT_RD : S_EDGE_LO;
          end
        end
        S_OUT_RD: begin
          state_q <= S_OUT_CAP;
        end
        S_OUT_CAP: begin
          done_q  <= 1'b1;
          state_q <= S_LOAD;
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != S_LOAD);
  assign done_o       = done_q;
  assign grid_error_o = err_q;

endmodule

// ----- rtl/three_point_stencil_time_stepper.sv -----
// top level of the explicit three-point stencil time stepper: config registers and glue
// depends on tpst_pkg, tpst_ctrl and tpst_datapath
//
// usage
//   input: a payoff word (q16.16) is taken at each rising edge with start high and
//   busy low, lowest grid price first, one word per cycle. last_i marks the final
//   grid point and starts the time stepping; busy then stays high until the result.
//   config: cfg_we_i writes cfg_data_i into register cfg_idx_i at once (coefficients,
//   low edge value, step count); write only while busy is low and no result is due.
//   output: done_o is high for exactly one cycle with option_value_o (q16.16 center
//   value) and grid_error_o; the receiver cannot stall, so the word must be taken then.
// timing
//   loading runs at one word per cycle. each time step writes both edge values, runs
//   the lower, center and upper multiply passes per interior point on the one shared
//   32x32 multiplier and drains the pipeline before the next step or the result.
//   a bad point count (even, below three or over capacity) returns zero with grid_error_o.
// reset
//   clears the load count, the control state and config registers to their defaults;
//   grid memories are not cleared and are only read where the current grid wrote them.
module three_point_stencil_time_stepper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tpst_pkg::DATA_W-1:0]  payoff_value_i,
  input  logic                                last_i,
  output logic                                done_o,
  output logic signed [tpst_pkg::DATA_W-1:0]  option_value_o,
  output logic                                grid_error_o,
  input  logic                                cfg_we_i,
  input  logic [tpst_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tpst_pkg::COEF_W-1:0]         cfg_data_i
);
  import tpst_pkg::*;

  // configuration registers
  logic signed [COEF_W-1:0] coef_lower_q, coef_center_q, coef_upper_q;
  logic [EDGE_W-1:0]        low_edge_q;
  logic [STEPS_W-1:0]       num_steps_q;

  tpst_cmd_t    cmd;
  tpst_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_lower_q  <= '0;
      coef_center_q <= COEF_CENTER_RST;
      coef_upper_q  <= '0;
      low_edge_q    <= '0;
      num_steps_q   <= NUM_STEPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COEF_LOWER:  coef_lower_q  <= $signed(cfg_data_i);
        CFG_COEF_CENTER: coef_center_q <= $signed(cfg_data_i);
        CFG_COEF_UPPER:  coef_upper_q  <= $signed(cfg_data_i);
        CFG_LOW_EDGE:    low_edge_q    <= cfg_data_i[EDGE_W-1:0];
        CFG_NUM_STEPS:   num_steps_q   <= cfg_data_i[STEPS_W-1:0];
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // sequencing: loading, grid check, step/point/phase counters, result strobe
  tpst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .last_i       (last_i),
    .num_steps_i  (num_steps_q),
    .status_i     (status),
    .cmd_o        (cmd),
    .busy_o       (busy),
    .done_o       (done_o),
    .grid_error_o (grid_error_o)
  );

  // grids, multiply-accumulate pipeline, rounding and output word
  tpst_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .payoff_value_i (payoff_value_i),
    .coef_lower_i   (coef_lower_q),
    .coef_center_i  (coef_center_q),
    .coef_upper_i   (coef_upper_q),
    .low_edge_i     (low_edge_q),
    .status_o       (status),
    .option_value_o (option_value_o)
  );

  // a result strobe is never high in consecutive cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  // an error result carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && grid_error_o) |-> (option_value_o == '0))
    else $error("error result with nonzero value");

  // the closing word always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> busy)
    else $error("last word did not start processing");

  // no memory traffic from the mac pipeline while loading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !done_o) |-> !status.pipe_busy)
    else $error("mac pipeline active while idle");

endmodule
